// ===== src/swr_pkg.sv =====
// shared types and constants for the sliding window receiver
package swr_pkg;

    localparam int SWR_WINDOW_SLOTS = 10;

    localparam logic [1:0] MODE_DATA     = 2'd0;
    localparam logic [1:0] MODE_WIN_DONE = 2'd1;
    localparam logic [1:0] MODE_END      = 2'd2;

    localparam logic [2:0] KIND_ACK     = 3'd0;
    localparam logic [2:0] KIND_NACK    = 3'd1;
    localparam logic [2:0] KIND_WIN_ACK = 3'd2;
    localparam logic [2:0] KIND_END_ACK = 3'd3;
    localparam logic [2:0] KIND_DELIVER = 3'd4;

    localparam logic [31:0] CODE_WIN_DONE = 32'hFFFF_FFF6;
    localparam logic [31:0] CODE_END      = 32'hFFFF_FF9D;

    typedef struct packed {
        logic       load_in;
        logic       emit;
        logic [2:0] out_kind;
        logic       out_last;
        logic       store_slot;
        logic       adv_expected;
        logic       clr_slot;
        logic       idx_clr;
        logic       idx_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       in_window;
        logic       is_expected;
        logic       any_valid;
        logic       cur_valid;
        logic       more_above;
    } t_dp_status;

endpackage

// ===== src/sliding_window_receiver_core.sv =====
// top level of the sliding window receiver
// Input channel (s_axis): one transaction per packet header. tuser holds the
// mode (data, window-done, end); tdata holds seq_num, pkt_size and
// payload_handle. Output channel (m_axis): one transaction per result; tuser
// holds the result kind, tdata the sequence, size and handle, tlast marks the
// final result of an input item.
// An input transaction is taken only when the previous item has issued all of
// its results into the output register. The input is captured in a register,
// then evaluated, and its first result is written into the output register
// once that is free. An in-order data packet gives an ack, an out-of-order
// one an ack then a nack, one outside the window no result. A marker gives its
// ack; if any slot is occupied, a flush then walks the slots up to the last
// occupied one, reading one slot per cycle but waiting at an occupied slot while the output register is full.
// Reset clears the expected sequence, all slot valid bits and the finished
// flag; no clearing pass is needed. After an end marker every input is taken
// and dropped until reset.
// When the receiver stalls, the pending result holds in the output register
// and the controller waits before writing the next one.
module sliding_window_receiver_core #(
    parameter int WINDOW_SLOTS = swr_pkg::SWR_WINDOW_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // seq_num[31:0], pkt_size[41:32], payload_handle[49:42]
    input  logic [1:0]  i_s_axis_tuser,  // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,  // out_seq[31:0], out_size[41:32], out_handle[49:42]
    output logic [2:0]  o_m_axis_tuser,  // kind[2:0]
    output logic        o_m_axis_tlast
);

    swr_pkg::t_dp_cmd    w_cmd;
    swr_pkg::t_dp_status w_status;
    logic [31:0] w_out_seq;
    logic [9:0]  w_out_size;
    logic [7:0]  w_out_handle;

    swr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    swr_datapath #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_mode           (i_s_axis_tuser),
        .i_seq_num        (i_s_axis_tdata[31:0]),
        .i_pkt_size       (i_s_axis_tdata[41:32]),
        .i_payload_handle (i_s_axis_tdata[49:42]),
        .o_kind           (o_m_axis_tuser),
        .o_out_seq        (w_out_seq),
        .o_out_size       (w_out_size),
        .o_out_handle     (w_out_handle),
        .o_last           (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, w_out_handle, w_out_size, w_out_seq};

endmodule

// ===== src/swr_datapath.sv =====
// datapath: input capture, expected sequence, slot store and output register
module swr_datapath #(
    parameter int WINDOW_SLOTS = swr_pkg::SWR_WINDOW_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swr_pkg::t_dp_cmd    i_cmd,
    output swr_pkg::t_dp_status o_status,
    input  logic [1:0]          i_mode,
    input  logic [31:0]         i_seq_num,
    input  logic [9:0]          i_pkt_size,
    input  logic [7:0]          i_payload_handle,
    output logic [2:0]          o_kind,
    output logic [31:0]         o_out_seq,
    output logic [9:0]          o_out_size,
    output logic [7:0]          o_out_handle,
    output logic                o_last
);

    localparam int IW = $clog2(WINDOW_SLOTS);
    localparam int DW = $clog2(WINDOW_SLOTS + 1);
    localparam int SW = $clog2(2 * WINDOW_SLOTS);

    logic [1:0]  r_mode;
    logic [31:0] r_seq;
    logic [9:0]  r_size;
    logic [7:0]  r_handle;

    logic [31:0] r_expected;
    logic [IW-1:0] r_exp_slot;
    logic [IW-1:0] r_idx;

    logic [WINDOW_SLOTS-1:0] r_slot_valid;
    logic [31:0] r_slot_seq    [WINDOW_SLOTS];
    logic [9:0]  r_slot_size   [WINDOW_SLOTS];
    logic [7:0]  r_slot_handle [WINDOW_SLOTS];

    logic [2:0]  r_out_kind;
    logic [31:0] r_out_seq;
    logic [9:0]  r_out_size;
    logic [7:0]  r_out_handle;
    logic        r_out_last;

    logic [31:0] w_diff;
    logic [SW-1:0] w_sum;
    logic [IW-1:0] w_slot;
    logic [WINDOW_SLOTS-1:0] w_upper_mask;

    // slot index from the running expected residue, no divider needed
    assign w_diff = r_seq - r_expected;
    assign w_sum  = SW'(r_exp_slot) + SW'(w_diff[DW-1:0]);
    assign w_slot = (w_sum >= SW'(WINDOW_SLOTS)) ? IW'(w_sum - SW'(WINDOW_SLOTS)) : IW'(w_sum);

    assign w_upper_mask = ~((WINDOW_SLOTS'(2) << r_idx) - WINDOW_SLOTS'(1));

    always_comb begin
        o_status.mode        = r_mode;
        o_status.in_window   = (r_seq >= r_expected) && (w_diff <= 32'(WINDOW_SLOTS));
        o_status.is_expected = (r_seq == r_expected);
        o_status.any_valid   = |r_slot_valid;
        o_status.cur_valid   = r_slot_valid[r_idx];
        o_status.more_above  = |(r_slot_valid & w_upper_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= '0;
            r_exp_slot   <= '0;
            r_idx        <= '0;
            r_slot_valid <= '0;
        end else begin
            if (i_cmd.adv_expected) begin
                r_expected <= r_expected + 32'd1;
                if (r_expected == '1 || r_exp_slot == IW'(WINDOW_SLOTS - 1)) begin
                    r_exp_slot <= '0;
                end else begin
                    r_exp_slot <= r_exp_slot + IW'(1);
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.store_slot && !r_slot_valid[w_slot]) begin
                r_slot_valid[w_slot] <= 1'b1;
            end
            if (i_cmd.clr_slot) begin
                r_slot_valid[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode   <= i_mode;
            r_seq    <= i_seq_num;
            r_size   <= i_pkt_size;
            r_handle <= i_payload_handle;
        end
        if (i_cmd.store_slot && !r_slot_valid[w_slot]) begin
            r_slot_seq[w_slot]    <= r_seq;
            r_slot_size[w_slot]   <= r_size;
            r_slot_handle[w_slot] <= r_handle;
        end
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_last <= i_cmd.out_last;
            case (i_cmd.out_kind)
                swr_pkg::KIND_ACK: begin
                    r_out_seq    <= r_seq;
                    r_out_size   <= r_size;
                    r_out_handle <= '0;
                end
                swr_pkg::KIND_NACK: begin
                    r_out_seq    <= r_expected;
                    r_out_size   <= '0;
                    r_out_handle <= '0;
                end
                swr_pkg::KIND_WIN_ACK: begin
                    r_out_seq    <= swr_pkg::CODE_WIN_DONE;
                    r_out_size   <= '0;
                    r_out_handle <= '0;
                end
                swr_pkg::KIND_END_ACK: begin
                    r_out_seq    <= swr_pkg::CODE_END;
                    r_out_size   <= '0;
                    r_out_handle <= '0;
                end
                default: begin
                    r_out_seq    <= r_slot_seq[r_idx];
                    r_out_size   <= r_slot_size[r_idx];
                    r_out_handle <= r_slot_handle[r_idx];
                end
            endcase
        end
    end

    assign o_kind       = r_out_kind;
    assign o_out_seq    = r_out_seq;
    assign o_out_size   = r_out_size;
    assign o_out_handle = r_out_handle;
    assign o_last       = r_out_last;

endmodule

// ===== src/swr_ctrl.sv =====
// controller state machine: sequences acks, nacks and window flushes
module swr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  swr_pkg::t_dp_status i_status,
    output swr_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_NACK,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_finished;
    logic   n_finished;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_finished = r_finished;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_finished) begin
                    n_state = S_IDLE;
                end else if (i_status.mode == swr_pkg::MODE_DATA) begin
                    if (!i_status.in_window) begin
                        n_state = S_IDLE;
                    end else if (w_out_free) begin
                        o_cmd.emit         = 1'b1;
                        o_cmd.out_kind     = swr_pkg::KIND_ACK;
                        o_cmd.out_last     = i_status.is_expected;
                        o_cmd.store_slot   = 1'b1;
                        o_cmd.adv_expected = i_status.is_expected;
                        n_state = i_status.is_expected ? S_IDLE : S_NACK;
                    end
                end else if (i_status.mode inside {swr_pkg::MODE_WIN_DONE, swr_pkg::MODE_END})
                begin
                    if (w_out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.out_kind = (i_status.mode == swr_pkg::MODE_END) ?
                                         swr_pkg::KIND_END_ACK : swr_pkg::KIND_WIN_ACK;
                        o_cmd.out_last = !i_status.any_valid;
                        o_cmd.idx_clr  = 1'b1;
                        n_finished     = (i_status.mode == swr_pkg::MODE_END);
                        n_state        = i_status.any_valid ? S_SCAN : S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_NACK: begin
                if (w_out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.out_kind = swr_pkg::KIND_NACK;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!i_status.cur_valid) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.out_kind = swr_pkg::KIND_DELIVER;
                    o_cmd.out_last = !i_status.more_above;
                    o_cmd.clr_slot = 1'b1;
                    o_cmd.idx_inc  = i_status.more_above;
                    if (!i_status.more_above) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> w_out_free)
        else $error("result written over a pending transaction");

    a_no_result_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) && r_finished |-> !o_cmd.emit)
        else $error("result produced after end of transfer");

    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> i_status.any_valid)
        else $error("flush running with no occupied slot");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && o_cmd.out_last |=> (r_state == S_IDLE))
        else $error("item still busy after its last result");

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the sliding window receiver core
`timescale 1ns / 100ps

module tb;

    localparam int         WINDOW      = swr_pkg::SWR_WINDOW_SLOTS;
    localparam logic [1:0] MODE_BAD    = 2'd3;
    localparam int         CLK_HALF    = 4;
    localparam int         LONG_HOLD   = 200;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         TAIL_CYCLES = 30;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] seq;
        logic [9:0]  size;
        logic [7:0]  handle;
        logic        last;
    } t_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [55:0] s_axis_tdata  = '0;  // seq_num[31:0], pkt_size[41:32], payload_handle[49:42]
    logic [1:0]  s_axis_tuser  = '0;  // mode[1:0]
    logic        m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [55:0] o_m_axis_tdata;      // out_seq[31:0], out_size[41:32], out_handle[49:42]
    logic [2:0]  o_m_axis_tuser;      // kind[2:0]
    logic        o_m_axis_tlast;

    t_result     pending_results[$];
    int          fail_count    = 0;
    int          quiet_cycles  = 0;
    bit          sender_idle   = 1'b1;
    bit          receiver_idle = 1'b1;
    bit          hold_request  = 1'b0;

    // receiver state mirror
    logic [31:0] rx_expected   = '0;
    logic        rx_finished   = 1'b0;
    logic        slot_used[WINDOW];
    logic [31:0] slot_seq[WINDOW];
    logic [9:0]  slot_size[WINDOW];
    logic [7:0]  slot_handle[WINDOW];

    sliding_window_receiver_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < WINDOW; i++) begin
            slot_used[i] = 1'b0;
        end
    end

    task automatic note_result(input logic [2:0] kind, input logic [31:0] seq,
                               input logic [9:0] size, input logic [7:0] handle,
                               input logic last);
        t_result r;
        r.kind   = kind;
        r.seq    = seq;
        r.size   = size;
        r.handle = handle;
        r.last   = last;
        pending_results.push_back(r);
    endtask

    task automatic flush_window(input logic [2:0] kind, input logic [31:0] code);
        int last_idx;
        last_idx = -1;
        for (int i = 0; i < WINDOW; i++) begin
            if (slot_used[i]) last_idx = i;
        end
        note_result(kind, code, '0, '0, last_idx < 0);
        for (int i = 0; i < WINDOW; i++) begin
            if (slot_used[i]) begin
                note_result(swr_pkg::KIND_DELIVER, slot_seq[i], slot_size[i], slot_handle[i],
                            i == last_idx);
                slot_used[i] = 1'b0;
            end
        end
    endtask

    task automatic predict_results(input logic [1:0] mode, input logic [31:0] seq,
                                   input logic [9:0] size, input logic [7:0] handle);
        logic [32:0] upper;
        int          slot;
        logic        in_order;
        if (rx_finished) return;
        case (mode)
            swr_pkg::MODE_DATA: begin
                upper = {1'b0, rx_expected} + 33'(WINDOW);
                if (seq < rx_expected || {1'b0, seq} > upper) return;
                in_order = (seq == rx_expected);
                note_result(swr_pkg::KIND_ACK, seq, size, '0, in_order);
                if (in_order) begin
                    rx_expected = rx_expected + 32'd1;
                end else begin
                    note_result(swr_pkg::KIND_NACK, rx_expected, '0, '0, 1'b1);
                end
                slot = int'(seq % WINDOW);
                if (!slot_used[slot]) begin
                    slot_used[slot]   = 1'b1;
                    slot_seq[slot]    = seq;
                    slot_size[slot]   = size;
                    slot_handle[slot] = handle;
                end
            end
            swr_pkg::MODE_WIN_DONE: flush_window(swr_pkg::KIND_WIN_ACK, swr_pkg::CODE_WIN_DONE);
            swr_pkg::MODE_END: begin
                flush_window(swr_pkg::KIND_END_ACK, swr_pkg::CODE_END);
                rx_finished = 1'b1;
            end
            default: return;
        endcase
    endtask

    task automatic send_item(input logic [1:0] mode, input logic [31:0] seq,
                             input logic [9:0] size, input logic [7:0] handle);
        int gap;
        gap = sender_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, handle, size, seq};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        predict_results(mode, seq, size, handle);
    endtask

    // receiver side: random gaps after each transaction, long hold on request
    initial begin
        int gap_left;
        gap_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid === 1'b1 && m_axis_tready)
                gap_left = receiver_idle ? $urandom_range(0, 9) : 0;
            if (hold_request) begin
                gap_left     = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (gap_left > 0) begin
                m_axis_tready <= 1'b0;
                gap_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d seq 0x%0h", o_m_axis_tuser,
                       o_m_axis_tdata[31:0]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_m_axis_tuser));
                check_field("out_seq", want.seq, o_m_axis_tdata[31:0]);
                check_field("out_size", 32'(want.size), 32'(o_m_axis_tdata[41:32]));
                check_field("out_handle", 32'(want.handle), 32'(o_m_axis_tdata[49:42]));
                check_field("last", 32'(want.last), 32'(o_m_axis_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && o_s_axis_tready === 1'b1) ||
            (o_m_axis_tvalid === 1'b1 && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic test_in_order();
        send_item(swr_pkg::MODE_DATA, rx_expected, 10'd0, 8'd0);
        send_item(swr_pkg::MODE_DATA, rx_expected, 10'd1023, 8'd255);
        send_item(swr_pkg::MODE_DATA, rx_expected, 10'd1000, 8'h5A);
        send_item(swr_pkg::MODE_DATA, rx_expected, 10'h2AA, 8'hA5);
    endtask

    task automatic test_out_of_order();
        logic [31:0] base;
        base = rx_expected;
        // top edge of the window, then just past it
        send_item(swr_pkg::MODE_DATA, base + WINDOW, 10'h155, 8'h3C);
        send_item(swr_pkg::MODE_DATA, base + WINDOW + 1, 10'h3FF, 8'hFF);
        // in order into a slot already taken by another sequence
        send_item(swr_pkg::MODE_DATA, base, 10'd64, 8'h11);
        send_item(swr_pkg::MODE_DATA, base - 1, 10'd5, 8'h22);
        send_item(swr_pkg::MODE_DATA, 32'hFFFF_FFFF, 10'd7, 8'h33);
        send_item(swr_pkg::MODE_DATA, rx_expected + 3, 10'd99, 8'h44);
        // duplicate keeps the stored descriptor
        send_item(swr_pkg::MODE_DATA, rx_expected + 3, 10'd100, 8'h55);
    endtask

    task automatic test_window_done();
        send_item(swr_pkg::MODE_WIN_DONE, $urandom, 10'($urandom), 8'($urandom));
        send_item(swr_pkg::MODE_WIN_DONE, $urandom, 10'($urandom), 8'($urandom));
    endtask

    task automatic test_unknown_mode();
        send_item(MODE_BAD, rx_expected, 10'($urandom), 8'($urandom));
        send_item(MODE_BAD, $urandom, 10'($urandom), 8'($urandom));
    endtask

    task automatic test_random(input int n_items);
        int          counted;
        int          pick;
        int          phase;
        logic [1:0]  mode;
        logic [31:0] seq;
        bit          productive;
        counted = 0;
        while (counted < n_items) begin
            if (counted % 50 == 0 && counted > 0) begin
                phase         = $urandom_range(0, 3);
                sender_idle   = phase[0];
                receiver_idle = phase[1];
            end
            pick       = $urandom_range(0, 99);
            mode       = swr_pkg::MODE_DATA;
            productive = 1'b1;
            if (pick < 8) begin
                mode = swr_pkg::MODE_WIN_DONE;
                seq  = $urandom;
            end else if (pick < 12) begin
                mode       = MODE_BAD;
                seq        = $urandom;
                productive = 1'b0;
            end else if (pick < 22) begin
                productive = 1'b0;
                case ($urandom_range(0, 2))
                    0: seq = (rx_expected > 0) ? $urandom_range(0, rx_expected - 1)
                                               : rx_expected + WINDOW + 1;
                    1: seq = rx_expected + WINDOW + 1 + $urandom_range(0, 1000);
                    default: seq = $urandom;
                endcase
            end else begin
                seq = rx_expected + ($urandom_range(0, 1) ? 0 : $urandom_range(1, WINDOW));
            end
            send_item(mode, seq, 10'($urandom), 8'($urandom));
            if (productive) counted++;
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        logic [31:0] seq;
        hold_request = 1'b1;
        sender_idle  = 1'b0;
        for (int i = 0; i < 24; i++) begin
            if (i % 8 == 7) begin
                send_item(swr_pkg::MODE_WIN_DONE, $urandom, 10'($urandom), 8'($urandom));
            end else begin
                seq = rx_expected + $urandom_range(0, WINDOW);
                send_item(swr_pkg::MODE_DATA, seq, 10'($urandom), 8'($urandom));
            end
        end
        sender_idle = 1'b1;
    endtask

    task automatic test_end();
        send_item(swr_pkg::MODE_DATA, rx_expected + 2, 10'd321, 8'h77);
        send_item(swr_pkg::MODE_DATA, rx_expected, 10'd123, 8'h88);
        send_item(swr_pkg::MODE_END, $urandom, 10'($urandom), 8'($urandom));
        // all dropped once the transfer is over
        send_item(swr_pkg::MODE_DATA, rx_expected, 10'd12, 8'h99);
        send_item(swr_pkg::MODE_WIN_DONE, $urandom, 10'($urandom), 8'($urandom));
        send_item(swr_pkg::MODE_END, $urandom, 10'($urandom), 8'($urandom));
        send_item(MODE_BAD, $urandom, 10'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_in_order();
        test_out_of_order();
        test_window_done();
        test_unknown_mode();
        test_random(250);
        test_backpressure();
        test_end();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/swr_pkg.sv
src/swr_datapath.sv
src/swr_ctrl.sv
src/sliding_window_receiver_core.sv
sim/tb.sv
